FILE: src/ara_pkg.sv
// ara_pkg: shared constants, channel codes and types for the round robin averager
// depends on nothing
`timescale 1ns / 1ps

package ara_pkg;

   localparam int SAMPLES_PER_AVERAGE = 16;
   localparam int SAMPLE_BITS = 12;

   localparam int SAMPLE_W = 12;
   localparam int SUM_W = 16;
   localparam int FRAC_BITS = 8;
   localparam int AVG_W = 20;
   localparam int CH_W = 2;
   localparam int CH_COUNT = 3;
   localparam int TAKEN_W = $clog2(SAMPLES_PER_AVERAGE + 1);
   localparam int AVG_WIDE_W = SUM_W + FRAC_BITS;

   localparam logic [SAMPLE_W-1:0] SAMPLE_MASK = SAMPLE_W'((32'd1 << SAMPLE_BITS) - 32'd1);
   localparam logic [TAKEN_W-1:0] TAKEN_FULL = TAKEN_W'(SAMPLES_PER_AVERAGE);
   localparam logic [AVG_W-1:0] AVG_MAX = '1;

   localparam logic [CH_W-1:0] CH_ANTENNA = 2'd0;
   localparam logic [CH_W-1:0] CH_BATTERY = 2'd1;
   localparam logic [CH_W-1:0] CH_OUT_STAGE = 2'd2;

   typedef struct packed {
      logic [CH_W-1:0]  channel;
      logic [AVG_W-1:0] average;
      logic [CH_W-1:0]  next_channel;
   } rsp_payload_type;

   typedef struct packed {
      logic            emit;
      rsp_payload_type payload;
   } core_status_type;

endpackage

FILE: src/ara_req_if.sv
// ara_req_if: sample channel, valid/ready handshake
// depends on ara_pkg
`timescale 1ns / 1ps

interface ara_req_if
   import ara_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink (input valid, input sample, output ready);
endinterface

FILE: src/ara_rsp_if.sv
// ara_rsp_if: result channel, valid/ready handshake
// depends on ara_pkg
`timescale 1ns / 1ps

interface ara_rsp_if
   import ara_pkg::*;
();
   logic             valid;
   logic             ready;
   logic [CH_W-1:0]  channel;
   logic [AVG_W-1:0] average;
   logic [CH_W-1:0]  next_channel;

   modport source (output valid, output channel, output average, output next_channel,
                   input ready);
   modport sink (input valid, input channel, input average, input next_channel,
                 output ready);
endinterface

FILE: src/ara_core.sv
// ara_core: accumulator, sample count, channel select and per-channel average store
// depends on ara_pkg
`timescale 1ns / 1ps

module ara_core
   import ara_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic [SAMPLE_W-1:0] sample,
   output core_status_type     status
);

   logic [SUM_W-1:0]      sum_ff, sum_in;
   logic [TAKEN_W-1:0]    taken_ff, taken_in;
   logic [CH_W-1:0]       channel_ff, channel_in;
   logic [AVG_W-1:0]      last_averages_ff [CH_COUNT];
   logic [SAMPLE_W-1:0]   smp;
   logic [AVG_WIDE_W-1:0] avg_wide;
   logic [AVG_W-1:0]      avg;
   logic [CH_W-1:0]       nxt;
   logic                  emit;

   assign smp = sample & SAMPLE_MASK;
   assign emit = (taken_ff == TAKEN_FULL);
   assign avg_wide = AVG_WIDE_W'({sum_ff, FRAC_BITS'(0)} / SAMPLES_PER_AVERAGE);
   assign avg = (avg_wide > AVG_WIDE_W'(AVG_MAX)) ? AVG_MAX : avg_wide[AVG_W-1:0];
   assign nxt = (channel_ff >= CH_OUT_STAGE) ? CH_ANTENNA : channel_ff + CH_BATTERY;

   always_comb begin
      sum_in = sum_ff;
      taken_in = taken_ff;
      channel_in = channel_ff;
      if (step) begin
         if (emit) begin
            sum_in = '0;
            taken_in = '0;
            channel_in = nxt;
         end else begin
            sum_in = sum_ff + SUM_W'(smp);
            taken_in = taken_ff + TAKEN_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
         taken_ff <= '0;
         channel_ff <= CH_ANTENNA;
         for (int i = 0; i < CH_COUNT; i++) begin
            last_averages_ff[i] <= '0;
         end
      end else begin
         sum_ff <= sum_in;
         taken_ff <= taken_in;
         channel_ff <= channel_in;
         if (step && emit && (channel_ff < CH_W'(CH_COUNT))) begin
            last_averages_ff[channel_ff] <= avg;
         end
      end
   end

   assign status.emit = emit;
   assign status.payload.channel = channel_ff;
   assign status.payload.average = avg;
   assign status.payload.next_channel = nxt;

`ifndef NO_ASSERTIONS
   a_taken_bound: assert property (@(posedge clock) disable iff (reset)
      taken_ff <= TAKEN_FULL)
      else $error("sample count beyond block size");

   a_clear_after_emit: assert property (@(posedge clock) disable iff (reset)
      step && emit |=> sum_ff == '0 && taken_ff == '0)
      else $error("accumulator not cleared after average");

   a_channel_reachable: assert property (@(posedge clock) disable iff (reset)
      channel_ff != 2'd3)
      else $error("channel select reached unused code");

   a_hold_when_idle: assert property (@(posedge clock) disable iff (reset)
      !step |=> $stable(sum_ff) && $stable(taken_ff) && $stable(channel_ff))
      else $error("state moved without a transaction");

   a_antenna_store: assert property (@(posedge clock) disable iff (reset)
      step && emit && channel_ff == CH_ANTENNA |=> last_averages_ff[0] == $past(avg))
      else $error("antenna average not stored");
`endif

endmodule

FILE: src/ara_out_stage.sv
// ara_out_stage: result register between the core and the result channel
// depends on ara_pkg
`timescale 1ns / 1ps

module ara_out_stage
   import ara_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            load,
   input  rsp_payload_type load_payload,
   output logic            free,
   output logic            out_valid,
   input  logic            out_ready,
   output rsp_payload_type out_payload
);

   logic            valid_ff, valid_in;
   rsp_payload_type payload_ff;

   assign free = !valid_ff || out_ready;
   assign valid_in = load || (valid_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) begin
         payload_ff <= load_payload;
      end
   end

   assign out_valid = valid_ff;
   assign out_payload = payload_ff;

endmodule

FILE: src/adc_round_robin_averager_unit.sv
// adc_round_robin_averager_unit: top level of the round robin block averager
// depends on ara_pkg, ara_req_if, ara_rsp_if, ara_core, ara_out_stage
`timescale 1ns / 1ps

// usage
//   req_chan carries one 12-bit converter sample per transaction for the channel
//   currently selected (antenna, battery, output-stage voltage, in that order).
//   every block of SAMPLES_PER_AVERAGE samples is summed; the sample after the
//   block is dropped and produces one rsp_chan transaction: the channel averaged,
//   its average (8 fractional bits) and the channel the mux should select next.
//   all other samples produce nothing on rsp_chan.
// timing
//   one sample accepted per cycle, but a closing sample waits while the output register is full;
//   the result is valid on rsp_chan the cycle after it is taken, held in that single register.
// reset
//   synchronous; clears the accumulator, the count, the per-channel averages and
//   selects the antenna channel. rsp_chan is empty after reset.
// stall
//   while a result waits on rsp_chan, samples that only accumulate are still
//   taken; a closing sample waits until the output register is free.

module adc_round_robin_averager_unit
   import ara_pkg::*;
(
   input logic         clock,
   input logic         reset,
   ara_req_if.sink     req_chan,
   ara_rsp_if.source   rsp_chan
);

   core_status_type status;
   rsp_payload_type out_payload;
   logic            step;
   logic            out_free;

   assign req_chan.ready = !status.emit || out_free;
   assign step = req_chan.valid && req_chan.ready;

   ara_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .sample (req_chan.sample),
      .status (status)
   );

   ara_out_stage u_out_stage (
      .clock        (clock),
      .reset        (reset),
      .load         (step && status.emit),
      .load_payload (status.payload),
      .free         (out_free),
      .out_valid    (rsp_chan.valid),
      .out_ready    (rsp_chan.ready),
      .out_payload  (out_payload)
   );

   assign rsp_chan.channel = out_payload.channel;
   assign rsp_chan.average = out_payload.average;
   assign rsp_chan.next_channel = out_payload.next_channel;

endmodule

FILE: dv/tb.sv
// tb: self-checking bench for adc_round_robin_averager_unit, predicts every block average
// depends on ara_pkg, ara_req_if, ara_rsp_if and the averager rtl
`timescale 1ns / 1ps

module tb;
   import ara_pkg::*;

   typedef enum int {
      IDLE_RX_HEAVY,
      IDLE_TX_HEAVY,
      IDLE_NONE
   } idle_mode_type;

   typedef struct {
      logic [SAMPLE_W-1:0] value;
      idle_mode_type       mode;
      bit                  drain_first;
      bit                  rx_hold;
   } sample_item_type;

   localparam int BLOCK_LEN = SAMPLES_PER_AVERAGE + 1;
   localparam int SAMPLE_TARGET = 1050;
   localparam int HEAVY_TX_START = 375;
   localparam int NO_IDLE_START = 725;
   localparam int RX_HOLD_AT = 800;
   localparam int RX_HOLD_CYCLES = 400;
   localparam int SETTLE_CYCLES = 16;
   localparam int CYCLE_LIMIT = 200000;
   localparam int REPORT_LIMIT = 10;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                req_valid = 1'b0;
   logic [SAMPLE_W-1:0] req_sample = '0;
   logic                rsp_ready = 1'b0;

   ara_req_if req_if ();
   ara_rsp_if rsp_if ();

   assign req_if.valid  = req_valid;
   assign req_if.sample = req_sample;
   assign rsp_if.ready  = rsp_ready;

   adc_round_robin_averager_unit u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   int tx_idle_pct [3] = '{18, 74, 0};
   int rx_idle_pct [3] = '{74, 18, 0};

   sample_item_type sample_q [$];
   rsp_payload_type expected_averages [$];

   // block accumulator mirror
   logic [SUM_W-1:0] acc_sum = '0;
   int unsigned      acc_count = 0;
   logic [CH_W-1:0]  sel_channel = CH_ANTENNA;
   logic [AVG_W-1:0] channel_avg [CH_COUNT] = '{default: '0};

   bit            req_took = 1'b0;
   idle_mode_type cur_mode = IDLE_RX_HEAVY;
   int            hold_requests = 0;
   int            hold_served = 0;
   int            hold_left = 0;
   int            samples_taken = 0;
   int            averages_checked = 0;
   int            mismatch_count = 0;
   int            channel_hits [4] = '{default: 0};
   int            cycle_count = 0;

   function automatic void accumulate_sample(input logic [SAMPLE_W-1:0] raw);
      logic [SAMPLE_W-1:0] used;
      logic [31:0]         wide;
      logic [CH_W-1:0]     next_sel;
      rsp_payload_type     exp;
      used = raw & SAMPLE_MASK;
      if (acc_count < SAMPLES_PER_AVERAGE) begin
         acc_sum = acc_sum + SUM_W'(used);
         acc_count++;
      end else begin
         wide = (32'(acc_sum) << FRAC_BITS) / SAMPLES_PER_AVERAGE;
         if (wide > 32'(AVG_MAX)) begin
            wide = 32'(AVG_MAX);
         end
         if (sel_channel < CH_COUNT) begin
            channel_avg[sel_channel] = wide[AVG_W-1:0];
         end
         next_sel = (sel_channel >= CH_OUT_STAGE) ? CH_ANTENNA : sel_channel + 1'b1;
         exp.channel = sel_channel;
         exp.average = wide[AVG_W-1:0];
         exp.next_channel = next_sel;
         expected_averages.push_back(exp);
         sel_channel = next_sel;
         acc_sum = '0;
         acc_count = 0;
      end
   endfunction

   function automatic void queue_sample(input logic [SAMPLE_W-1:0] value);
      sample_item_type item;
      int              pos;
      pos = sample_q.size();
      item.value = value;
      item.mode = (pos < HEAVY_TX_START) ? IDLE_RX_HEAVY :
                  (pos < NO_IDLE_START) ? IDLE_TX_HEAVY : IDLE_NONE;
      item.drain_first = (pos == HEAVY_TX_START || pos == 550 || pos == NO_IDLE_START);
      item.rx_hold = (pos == RX_HOLD_AT);
      sample_q.push_back(item);
   endfunction

   // sample acceptance and prediction
   always @(posedge clock) begin
      req_took = 1'b0;
      if (!reset && req_valid && req_if.ready) begin
         req_took = 1'b1;
         accumulate_sample(req_sample);
         cur_mode = sample_q[0].mode;
         if (sample_q[0].rx_hold) begin
            hold_requests++;
         end
         sample_q.pop_front();
         samples_taken++;
      end
   end

   // driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_took) begin
         if (sample_q.size() == 0) begin
            req_valid <= 1'b0;
         end else if (sample_q[0].drain_first && expected_averages.size() != 0) begin
            req_valid <= 1'b0;
         end else if ($urandom_range(0, 99) < tx_idle_pct[sample_q[0].mode]) begin
            req_valid <= 1'b0;
         end else begin
            req_valid <= 1'b1;
            req_sample <= sample_q[0].value;
         end
      end
   end

   // result ready, with a long hold-off on request
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left--;
      end else if (hold_served != hold_requests) begin
         hold_served = hold_requests;
         hold_left = RX_HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= rx_idle_pct[cur_mode]);
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_payload_type exp;
      if (!reset && rsp_ready && rsp_if.valid) begin
         if (expected_averages.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
               $display("unexpected transaction: ch %0d avg 0x%05h next %0d",
                        rsp_if.channel, rsp_if.average, rsp_if.next_channel);
            end
         end else begin
            exp = expected_averages.pop_front();
            averages_checked++;
            channel_hits[exp.channel]++;
            if (rsp_if.channel !== exp.channel || rsp_if.average !== exp.average ||
                rsp_if.next_channel !== exp.next_channel) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT) begin
                  $display("average %0d: expected ch %0d avg 0x%05h next %0d",
                           averages_checked, exp.channel, exp.average, exp.next_channel);
                  $display("   got ch %0d avg 0x%05h next %0d",
                           rsp_if.channel, rsp_if.average, rsp_if.next_channel);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d samples left", cycle_count, sample_q.size());
         $display("adc_round_robin_averager_unit: mismatch");
         $finish;
      end
   end

   initial begin
      int                  chunk;
      int                  kind;
      logic [SAMPLE_W-1:0] value;

      // full-scale block, then zero, bit patterns and edge codes
      repeat (BLOCK_LEN) queue_sample({SAMPLE_W{1'b1}});
      queue_sample('0);
      queue_sample(12'hAAA);
      queue_sample(12'h555);
      queue_sample(12'h001);
      queue_sample(12'h800);
      queue_sample('0);
      queue_sample(12'h7FF);
      queue_sample({SAMPLE_W{1'b1}});

      while (sample_q.size() < SAMPLE_TARGET) begin
         chunk = BLOCK_LEN - (sample_q.size() % BLOCK_LEN);
         kind = $urandom_range(0, 9);
         for (int i = 0; i < chunk; i++) begin
            case (kind)
               0: begin
                  value = '0;
               end
               1: begin
                  value = {SAMPLE_W{1'b1}};
               end
               2: begin
                  value = SAMPLE_W'($urandom_range(0, 15));
               end
               3: begin
                  value = SAMPLE_W'($urandom_range(4080, 4095));
               end
               default: begin
                  value = SAMPLE_W'($urandom());
               end
            endcase
            queue_sample(value);
         end
      end

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (sample_q.size() != 0 || expected_averages.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("%0d samples driven, %0d averages checked",
               samples_taken, averages_checked);
      $display("per channel: antenna %0d, battery %0d, output stage %0d",
               channel_hits[CH_ANTENNA], channel_hits[CH_BATTERY],
               channel_hits[CH_OUT_STAGE]);
      $display("stalls covered: idle mixes both sides, %0d-cycle hold-off, drain pauses",
               RX_HOLD_CYCLES);
      if (mismatch_count == 0) begin
         $display("adc_round_robin_averager_unit: match");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("adc_round_robin_averager_unit: mismatch");
      end
      $finish;
   end

endmodule
